@@ src/tms_pkg.sv @@
// tms_pkg: types, constants and the microcode table of the tone melody sequencer
// no dependencies; imported by tone_melody_sequencer and tone_melody_sequencer_tb
package tms_pkg;

    // note table
    localparam int NOTE_REGS      = 6;
    localparam int NOTE_COUNT_DEF = 6;
    localparam int NOTE_W         = 25;
    localparam int NOTE_IDX_W     = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int STOP_BIT       = 24;
    localparam int FREQ_W         = 12;
    localparam int DUR_W          = 12;

    localparam logic [NOTE_W-1:0] NOTE_RESET [NOTE_REGS] = '{
        25'd3604730, 25'd30, 25'd2699514, 25'd30, 25'd2269634, 25'd16777216
    };

    // tone divider
    localparam int               DIVIDEND_W = 21;
    localparam logic [20:0]      PIT_CLOCK  = 21'd1193182;
    localparam logic [FREQ_W-1:0] BEEP_HZ   = 12'd1000;
    localparam int               DIV_CNT_W  = 5;
    localparam logic [4:0]       DIV_STEPS  = 5'd21;

    // duration ms to ticks: x / 5 == (x * 52429) >> 18 for 12-bit x
    localparam logic [15:0]      RECIP_5    = 16'd52429;
    localparam int               RECIP_SH   = 18;
    localparam int               PROD_W     = DUR_W + 16;

    // item kinds
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_BEEP  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] current_tick;
    } in_item_t;

    typedef struct packed {
        logic        speaker_on;
        logic [15:0] divisor;
        logic        divisor_loaded;
        logic        divisor_overflow;
        logic        playing;
    } out_item_t;

    // microcode
    typedef logic [3:0] upc_t;

    localparam upc_t U_EMIT     = 4'd0;
    localparam upc_t U_WAIT     = 4'd1;
    localparam upc_t U_DISPATCH = 4'd2;
    localparam upc_t U_START    = 4'd3;
    localparam upc_t U_BEEP     = 4'd4;
    localparam upc_t U_TONE_MUL = 4'd5;
    localparam upc_t U_TONE_ADV = 4'd6;
    localparam upc_t U_GAP_MUL  = 4'd7;
    localparam upc_t U_GAP_ADV  = 4'd8;
    localparam upc_t U_END      = 4'd9;
    localparam upc_t U_DIV      = 4'd10;
    localparam upc_t U_DIV_DONE = 4'd11;

    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NO_ACCEPT = 3'd2,
        COND_DIV_BUSY  = 3'd3,
        COND_OUT_FULL  = 3'd4
    } cond_t;

    typedef struct packed {
        logic  ready;
        logic  dispatch;
        logic  act_start;
        logic  act_mul;
        logic  act_adv;
        logic  act_gate_off;
        logic  act_end;
        logic  act_div_init;
        logic  beep_sel;
        logic  act_div_step;
        logic  act_load;
        logic  act_emit;
        cond_t cond;
        upc_t  target;
    } uword_t;

    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        w        = '0;
        w.cond   = COND_NEVER;
        w.target = U_EMIT;
        case (addr)
            U_EMIT: begin
                w.act_emit = 1'b1;
                w.cond     = COND_OUT_FULL;
                w.target   = U_EMIT;
            end
            U_WAIT: begin
                w.ready  = 1'b1;
                w.cond   = COND_NO_ACCEPT;
                w.target = U_WAIT;
            end
            U_DISPATCH: begin
                w.dispatch = 1'b1;
            end
            U_START: begin
                w.act_start = 1'b1;
                w.cond      = COND_ALWAYS;
            end
            U_BEEP: begin
                w.act_div_init = 1'b1;
                w.beep_sel     = 1'b1;
                w.cond         = COND_ALWAYS;
                w.target       = U_DIV;
            end
            U_TONE_MUL: begin
                w.act_mul = 1'b1;
            end
            U_TONE_ADV: begin
                w.act_adv      = 1'b1;
                w.act_div_init = 1'b1;
                w.cond         = COND_ALWAYS;
                w.target       = U_DIV;
            end
            U_GAP_MUL: begin
                w.act_mul = 1'b1;
            end
            U_GAP_ADV: begin
                w.act_adv      = 1'b1;
                w.act_gate_off = 1'b1;
                w.cond         = COND_ALWAYS;
            end
            U_END: begin
                w.act_end = 1'b1;
                w.cond    = COND_ALWAYS;
            end
            U_DIV: begin
                w.act_div_step = 1'b1;
                w.cond         = COND_DIV_BUSY;
                w.target       = U_DIV;
            end
            U_DIV_DONE: begin
                w.act_load = 1'b1;
                w.cond     = COND_ALWAYS;
            end
            default: begin
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/tone_melody_sequencer.sv @@
// tone_melody_sequencer: microcoded note table player for a square-wave speaker
// depends on tms_pkg (types, constants, microcode table)
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_data  (op, current_tick)
// m_        out        m_valid / m_ready  m_data  (gate, divisor, flags, playing)
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (note_0..note_5)
//
// a transaction runs from acceptance through the dispatch step and its routine
// to the emit step, then back to idle; unused op or tick with nothing due goes
// to emit, start or stop entry runs its own step, a silent gap multiply and advance;
// beep and tone add a 21-step restoring 1193182/freq divide, one quotient bit per cycle
// the next input transaction is taken as soon as the result sits in the output
// register, even while that register still waits for m_ready
// aresetn (synchronous, low) restores the note table and stops the sequence

module tone_melody_sequencer
    import tms_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NOTE_W-1:0]    cfg_wdata
);

    localparam int POS_W = $clog2(NOTE_COUNT + 1);

    // sequencer
    upc_t   upc_reg, upc_next;
    uword_t uw;
    logic   take_jump;
    upc_t   dispatch_tgt;

    // configuration table
    logic [NOTE_W-1:0] notes_reg [NOTE_REGS];

    // latched transaction
    logic [1:0]  op_reg;
    logic [31:0] tick_reg;

    // sequence state
    logic             active_reg;
    logic [POS_W-1:0] pos_reg;
    logic [31:0]      next_evt_reg;
    logic             gate_reg;
    logic [15:0]      divisor_reg;
    logic             loaded_reg;
    logic             ovf_reg;

    // datapath
    logic [NOTE_W-1:0]     entry_reg;
    logic [NOTE_W-1:0]     entry_cur;
    logic [3:0]            pos_ext;
    logic [PROD_W-1:0]     prod_reg;
    logic [FREQ_W-1:0]     den_reg;
    logic [FREQ_W-1:0]     rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [FREQ_W:0]       trial;
    logic [FREQ_W:0]       diff;
    logic                  q_bit;

    // output register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      out_full;
    logic      s_accept;

    assign uw       = ucode_rom(upc_reg);
    assign s_ready  = uw.ready;
    assign s_accept = s_valid && s_ready;
    assign out_full = out_valid_reg && !m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // current note entry; positions without a register read as stop
    assign pos_ext = 4'(pos_reg);
    always_comb begin
        entry_cur = NOTE_W'(1) << STOP_BIT;
        if (pos_ext < 4'(NOTE_REGS)) begin
            entry_cur = notes_reg[pos_ext[NOTE_IDX_W-1:0]];
        end
    end

    // dispatch map: decoded transaction kind to routine entry point
    always_comb begin
        dispatch_tgt = U_EMIT;
        case (op_reg)
            OP_START: dispatch_tgt = U_START;
            OP_BEEP:  dispatch_tgt = U_BEEP;
            OP_TICK: begin
                if (active_reg && (tick_reg >= next_evt_reg)) begin
                    if ((pos_ext >= 4'(NOTE_COUNT)) || entry_cur[STOP_BIT]) begin
                        dispatch_tgt = U_END;
                    end else if (entry_cur[DUR_W +: FREQ_W] == '0) begin
                        dispatch_tgt = U_GAP_MUL;
                    end else begin
                        dispatch_tgt = U_TONE_MUL;
                    end
                end
            end
            default: dispatch_tgt = U_EMIT;
        endcase
    end

    // next microcode address
    always_comb begin
        case (uw.cond)
            COND_NEVER:     take_jump = 1'b0;
            COND_ALWAYS:    take_jump = 1'b1;
            COND_NO_ACCEPT: take_jump = !s_accept;
            COND_DIV_BUSY:  take_jump = (cnt_reg != DIV_CNT_W'(1));
            COND_OUT_FULL:  take_jump = out_full;
            default:        take_jump = 1'b1;
        endcase
        if (uw.dispatch) begin
            upc_next = dispatch_tgt;
        end else if (take_jump) begin
            upc_next = uw.target;
        end else begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    // one restoring divider step
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign q_bit = (trial >= {1'b0, den_reg});

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg       <= U_WAIT;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            next_evt_reg  <= '0;
            gate_reg      <= 1'b0;
            divisor_reg   <= '0;
            for (int i = 0; i < NOTE_REGS; i++) begin
                notes_reg[i] <= NOTE_RESET[i];
            end
        end else begin
            upc_reg <= upc_next;

            if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NOTE_REGS))) begin
                notes_reg[cfg_index] <= cfg_wdata;
            end

            if (uw.act_emit && !out_full) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // start: rewind, due at once; gate and divisor stay
            if (uw.act_start) begin
                active_reg   <= 1'b1;
                pos_reg      <= '0;
                next_evt_reg <= tick_reg;
            end

            // advance to the next entry, event duration/5 ticks later
            if (uw.act_adv) begin
                next_evt_reg <= tick_reg + 32'(prod_reg[PROD_W-1:RECIP_SH]);
                pos_reg      <= pos_reg + POS_W'(1);
            end

            if (uw.act_gate_off) begin
                gate_reg <= 1'b0;
            end

            // stop entry or past the table end
            if (uw.act_end) begin
                gate_reg   <= 1'b0;
                active_reg <= 1'b0;
            end

            if (uw.act_load) begin
                divisor_reg <= quo_reg[15:0];
                gate_reg    <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg     <= s_data.op;
            tick_reg   <= s_data.current_tick;
            loaded_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end

        if (uw.dispatch) begin
            entry_reg <= entry_cur;
        end

        if (uw.act_mul) begin
            prod_reg <= entry_reg[DUR_W-1:0] * RECIP_5;
        end

        if (uw.act_div_init) begin
            den_reg <= uw.beep_sel ? BEEP_HZ : entry_reg[DUR_W +: FREQ_W];
            quo_reg <= PIT_CLOCK;
            rem_reg <= '0;
            cnt_reg <= DIV_STEPS;
        end

        if (uw.act_div_step) begin
            rem_reg <= q_bit ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], q_bit};
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end

        if (uw.act_load) begin
            loaded_reg <= 1'b1;
            ovf_reg    <= |quo_reg[DIVIDEND_W-1:16];
        end

        if (uw.act_emit && !out_full) begin
            out_data_reg.speaker_on       <= gate_reg;
            out_data_reg.divisor          <= divisor_reg;
            out_data_reg.divisor_loaded   <= loaded_reg;
            out_data_reg.divisor_overflow <= ovf_reg;
            out_data_reg.playing          <= active_reg;
        end
    end

endmodule

@@ bench/tone_melody_sequencer_tb.sv @@
`timescale 1ns / 1ps
// tone_melody_sequencer_tb: self-checking bench for the note table player
// depends on tms_pkg and tone_melody_sequencer; directed table first, then random phases

module tone_melody_sequencer_tb;
    import tms_pkg::*;

    // sequence length of the instance under test
    localparam int SEQ_LEN     = NOTE_COUNT_DEF;
    localparam int MS_PER_TICK = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 220;

    // op code the block leaves undefined
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_5  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one line of the directed table: a register write or an input transaction,
    // optionally with a hand-written expected result
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [NOTE_W-1:0]    reg_val;
        in_item_t             item;
        logic                 pinned;
        out_item_t            result;
    } stim_row_t;

    typedef struct packed {
        logic      on;
        out_item_t val;
    } pin_t;

    localparam int DIR_ROWS = 33;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [NOTE_W-1:0]    cfg_wdata = '0;

    // predicted block state, kept in step with accepted transactions
    logic [NOTE_W-1:0] tone_table [NOTE_REGS];
    logic              seq_active;
    logic [3:0]        seq_pos;
    logic [31:0]       due_tick;
    logic              gate_on;
    logic [15:0]       cur_divisor;

    out_item_t speaker_state_q [$];  // expected results, oldest first
    pin_t      pin_q [$];            // hand-written results of directed rows

    int        mismatch_count = 0;
    int        results_seen   = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_req       = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;

    stim_row_t directed [DIR_ROWS];

    tone_melody_sequencer #(
        .NOTE_COUNT(SEQ_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit, far above the slowest legal run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [NOTE_W-1:0] note_word(input logic stop,
                                                    input logic [FREQ_W-1:0] freq,
                                                    input logic [DUR_W-1:0] dur);
        return {stop, freq, dur};
    endfunction

    // advance the predicted state by one transaction and return the result it reports
    function automatic out_item_t play_step(input in_item_t item);
        out_item_t         r;
        logic [NOTE_W-1:0] entry;
        logic [FREQ_W-1:0] freq;
        logic [31:0]       quot;
        logic              loaded;
        logic              ovf;
        loaded = 1'b0;
        ovf    = 1'b0;
        freq   = '0;
        case (item.op)
            OP_START: begin
                seq_active = 1'b1;
                seq_pos    = '0;
                due_tick   = item.current_tick;
            end
            OP_BEEP: begin
                freq = BEEP_HZ;
            end
            OP_TICK: begin
                if (seq_active && item.current_tick >= due_tick) begin
                    // positions past the table, or without a register, read as stop
                    entry = '0;
                    entry[STOP_BIT] = 1'b1;
                    if (seq_pos < SEQ_LEN && seq_pos < NOTE_REGS)
                        entry = tone_table[seq_pos];
                    if (seq_pos >= SEQ_LEN || entry[STOP_BIT]) begin
                        gate_on    = 1'b0;
                        seq_active = 1'b0;
                    end else begin
                        freq = entry[DUR_W +: FREQ_W];
                        if (freq == '0)
                            gate_on = 1'b0;
                        due_tick = item.current_tick
                                 + 32'(entry[DUR_W-1:0]) / 32'(MS_PER_TICK);
                        seq_pos++;
                    end
                end
            end
            default: begin
            end
        endcase
        // tone load: divide the timer clock, keep the low 16 bits
        if (freq != '0) begin
            quot        = 32'(PIT_CLOCK) / 32'(freq);
            cur_divisor = quot[15:0];
            ovf         = quot > 32'h0000_FFFF;
            loaded      = 1'b1;
            gate_on     = 1'b1;
        end
        r.speaker_on       = gate_on;
        r.divisor          = cur_divisor;
        r.divisor_loaded   = loaded;
        r.divisor_overflow = ovf;
        r.playing          = seq_active;
        return r;
    endfunction

    // input side: register writes and accepted transactions feed the predictor
    always @(posedge aclk) begin : predict
        pin_t      pin;
        out_item_t want;
        if (aresetn) begin
            if (cfg_wr_en && cfg_index < NOTE_REGS)
                tone_table[cfg_index] = cfg_wdata;
            if (s_valid && s_ready) begin
                want = play_step(s_data);
                if (pin_q.size() != 0) begin
                    pin = pin_q.pop_front();
                    if (pin.on)
                        want = pin.val;
                end
                speaker_state_q.push_back(want);
            end
        end
    end

    // output side: each result transaction against the oldest expectation
    always @(posedge aclk) begin : compare
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (speaker_state_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = speaker_state_q.pop_front();
                if (m_data.speaker_on !== want.speaker_on
                        || m_data.divisor !== want.divisor
                        || m_data.divisor_loaded !== want.divisor_loaded
                        || m_data.divisor_overflow !== want.divisor_overflow
                        || m_data.playing !== want.playing) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: exp on=%0b div=%0d ld=%0b ovf=%0b play=%0b %s",
                                 results_seen, want.speaker_on, want.divisor,
                                 want.divisor_loaded, want.divisor_overflow, want.playing,
                                 $sformatf("got on=%0b div=%0d ld=%0b ovf=%0b play=%0b",
                                           m_data.speaker_on, m_data.divisor,
                                           m_data.divisor_loaded, m_data.divisor_overflow,
                                           m_data.playing));
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // sender: optional idle cycles, then hold valid until the transaction is taken
    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and let every expected result come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (speaker_state_q.size() != 0);
    endtask

    task automatic write_note(input logic [CFG_IDX_W-1:0] idx, input logic [NOTE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    function automatic stim_row_t item_row(input logic [1:0] op, input logic [31:0] tick);
        stim_row_t row;
        row                   = '0;
        row.kind              = ROW_ITEM;
        row.item.op           = op;
        row.item.current_tick = tick;
        return row;
    endfunction

    function automatic stim_row_t pin_row(input logic [1:0] op, input logic [31:0] tick,
                                          input out_item_t result);
        stim_row_t row;
        row        = item_row(op, tick);
        row.pinned = 1'b1;
        row.result = result;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [NOTE_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // mostly playable notes: short gaps, some silent, some overflowing, some stops
    function automatic logic [NOTE_W-1:0] random_note();
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        if ($urandom_range(0, 7) == 0)
            return NOTE_W'($urandom);
        case ($urandom_range(0, 5))
            0:       freq = '0;
            1:       freq = FREQ_W'($urandom_range(1, 20));
            2:       freq = '1;
            default: freq = FREQ_W'($urandom_range(1, 4095));
        endcase
        dur = ($urandom_range(0, 9) == 0) ? '1 : DUR_W'($urandom_range(0, 60));
        return note_word($urandom_range(0, 11) == 0, freq, dur);
    endfunction

    // one random phase: fresh note table, then melodies driven by a running tick count
    task automatic play_phase(input int idle_pct, input int stall_pct,
                              input logic hold_mid, input logic pause_mid);
        in_item_t    item;
        logic [31:0] now;
        int          roll;
        wait_for_results();
        for (int r = REG_NOTE_0; r <= REG_NOTE_5; r++)
            write_note(CFG_IDX_W'(r), random_note());
        if ($urandom_range(0, 1) != 0)
            write_note(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7, random_note());
        cfg_wr_en      <= 1'b0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        now            = $urandom;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
                // fill the block against a stalled receiver
                if (hold_mid)
                    hold_req++;
                // quiet the sender until the block has drained
                if (pause_mid)
                    wait_for_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 7) begin
                case ($urandom_range(0, 3))
                    0: now = $urandom;
                    1: now = 32'hFFFF_FFFF - $urandom_range(0, 40);
                    default: begin
                    end
                endcase
                item.op           = OP_START;
                item.current_tick = now;
            end else if (roll < 11) begin
                item.op           = OP_BEEP;
                item.current_tick = ($urandom_range(0, 1) != 0) ? now : $urandom;
            end else if (roll < 13) begin
                item.op           = OP_UNUSED;
                item.current_tick = $urandom;
            end else if (roll < 16) begin
                item.op           = OP_TICK;
                item.current_tick = $urandom;
            end else begin
                if ($urandom_range(0, 19) == 0)
                    now = now + $urandom_range(0, 900);
                else
                    now = now + $urandom_range(0, 5);
                item.op           = OP_TICK;
                item.current_tick = now;
            end
            send_item(item);
        end
    endtask

    initial begin
        logic cfg_open;
        cfg_open = 1'b0;

        // predictor starts from the reset state
        foreach (tone_table[i])
            tone_table[i] = NOTE_RESET[i];
        seq_active  = 1'b0;
        seq_pos     = '0;
        due_tick    = '0;
        gate_on     = 1'b0;
        cur_divisor = '0;

        directed = '{
            // after reset nothing plays
            pin_row(OP_TICK,   32'd0,        {1'b0, 16'd0, 1'b0, 1'b0, 1'b0}),
            pin_row(OP_UNUSED, 32'hFFFF_FFFF, {1'b0, 16'd0, 1'b0, 1'b0, 1'b0}),
            // beep at 1000 Hz, then a start that keeps gate and divisor
            pin_row(OP_BEEP,   32'd5,        {1'b1, 16'd1193, 1'b1, 1'b0, 1'b0}),
            pin_row(OP_START,  32'd100,      {1'b1, 16'd1193, 1'b0, 1'b0, 1'b1}),
            // default melody: early tick, tone, gap, beep while playing, to the stop entry
            item_row(OP_TICK,  32'd99),
            item_row(OP_TICK,  32'd100),
            item_row(OP_TICK,  32'd150),
            item_row(OP_BEEP,  32'd151),
            item_row(OP_TICK,  32'd156),
            item_row(OP_TICK,  32'd300),
            item_row(OP_TICK,  32'd400),
            item_row(OP_TICK,  32'hFFFF_FFFF),
            // next event wraps past the top of the tick range
            item_row(OP_START, 32'hFFFF_FFF0),
            item_row(OP_TICK,  32'hFFFF_FFF0),
            item_row(OP_TICK,  32'd16),
            item_row(OP_TICK,  32'hFFFF_FFF1),
            // restart while a melody is active
            item_row(OP_START, 32'd7),
            // extreme table without a stop entry; writes past the last register
            cfg_row(REG_NOTE_0,  note_word(1'b0, 12'd1,    12'd4095)),
            cfg_row(REG_NOTE_1,  note_word(1'b0, 12'd4095, 12'd0)),
            cfg_row(REG_NOTE_2,  note_word(1'b0, 12'd18,   12'd0)),
            cfg_row(REG_NOTE_3,  note_word(1'b0, 12'd19,   12'd4)),
            cfg_row(REG_NOTE_4,  note_word(1'b0, 12'd0,    12'd0)),
            cfg_row(REG_NOTE_5,  note_word(1'b0, 12'd4095, 12'd9)),
            cfg_row(REG_SPARE_6, 25'h1FF_FFFF),
            cfg_row(REG_SPARE_7, note_word(1'b1, 12'd0,    12'd0)),
            item_row(OP_START, 32'd0),
            // 1 Hz overflows the 16-bit divisor
            pin_row(OP_TICK,   32'd0,        {1'b1, 16'd13534, 1'b1, 1'b1, 1'b1}),
            item_row(OP_TICK,  32'd819),
            item_row(OP_TICK,  32'd819),
            item_row(OP_TICK,  32'd820),
            item_row(OP_TICK,  32'd820),
            item_row(OP_TICK,  32'd820),
            // running past the last entry ends the melody
            pin_row(OP_TICK,   32'd821,      {1'b0, 16'd291, 1'b0, 1'b0, 1'b0})
        };

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                // registers change only while the block is idle
                if (!cfg_open)
                    wait_for_results();
                write_note(directed[i].reg_idx, directed[i].reg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_wr_en <= 1'b0;
                    cfg_open = 1'b0;
                end
                pin_q.push_back({directed[i].pinned, directed[i].result});
                send_item(directed[i].item);
            end
        end

        // random phases: no idling, idle sender, stalling receiver with a long
        // hold-off, both with a mid-phase drain, no idling again
        play_phase(0, 0, 1'b0, 1'b0);
        play_phase(69, 0, 1'b0, 1'b0);
        play_phase(0, 69, 1'b1, 1'b0);
        play_phase(22, 22, 1'b0, 1'b1);
        play_phase(0, 0, 1'b0, 1'b0);

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
src/tms_pkg.sv
src/tone_melody_sequencer.sv
bench/tone_melody_sequencer_tb.sv
